// File: hdl/ott_pkg.sv
// Shared types, codes and constants of the one-shot timer table.
package ott_pkg;

	// Field widths
	localparam int TICK_W   = 20;
	localparam int PERIOD_W = 32;
	localparam int SLOT_W   = 4;
	localparam int SEC_W    = 32;
	localparam int SUB_W    = 10;
	// Sum of sub-second time and one tick length: below 2 * 2^20
	localparam int TOT_W    = 21;

	localparam int SLOTS_DEF = 16;

	// Time constants
	localparam int unsigned US_PER_MS = 1000;
	localparam int unsigned US_PER_S  = 1000000;
	// ceil(2^30 / 1000): exact quotient by 1000 for values below 2^22
	localparam int unsigned RECIP_1000  = 1073742;
	localparam int          RECIP_SHIFT = 30;
	localparam int          PROD_W      = 41;

	localparam logic [TICK_W-1:0] TICK_LEN_RST = 20'd1000;

	// Input modes
	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_START  = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// Result kinds
	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_TIME   = 1'b1;

	// Main sequencer
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DIV,
		CS_TIME,
		CS_WALK,
		CS_FLUSH,
		CS_READ
	} ctl_state_t;

	// Time-of-day update
	typedef enum logic [1:0] {
		TS_IDLE,
		TS_WRAP,
		TS_MUL,
		TS_SPLIT
	} time_state_t;

endpackage

// File: hdl/ott_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ott_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/ott_div.sv
// Restoring divider, one quotient bit per cycle, giving the ceiling tick count.
module ott_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ott_pkg::PERIOD_W-1:0] dividend,
	input  logic [ott_pkg::TICK_W-1:0]   divisor,
	output logic                          done,
	output logic [ott_pkg::PERIOD_W-1:0] ticks
);
	import ott_pkg::*;

	localparam int CNT_W = $clog2(PERIOD_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TICK_W-1:0]   dvs_q;
	logic [TICK_W-1:0]   rem_q;
	logic [PERIOD_W-1:0] quo_q;
	logic [PERIOD_W-1:0] ticks_q;

	logic [TICK_W:0]     rem_sh;
	logic                ge;
	logic [TICK_W-1:0]   rem_nx;
	logic [PERIOD_W-1:0] quo_nx;
	logic                round_up;

	// one shift-subtract step
	always_comb begin
		rem_sh   = {rem_q, quo_q[PERIOD_W-1]};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_nx   = ge ? TICK_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[TICK_W-1:0];
		quo_nx   = {quo_q[PERIOD_W-2:0], ge};
		// ceiling, and at least one tick
		round_up = (quo_nx == '0) || (rem_nx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PERIOD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				ticks_q <= quo_nx + {{(PERIOD_W-1){1'b0}}, round_up};
			end
		end
	end

	assign done  = done_q;
	assign ticks = ticks_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> (ticks_q != '0))
		else $error("divider gave a zero tick count");

endmodule

// File: hdl/ott_time.sv
// Time-of-day counter: adds one tick length and renormalizes through its wrap, multiply and split states.
module ott_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ott_pkg::TICK_W-1:0] len,
	output logic                        done,
	output logic [ott_pkg::SEC_W-1:0]  seconds,
	output logic [ott_pkg::SUB_W-1:0]  millis,
	output logic [ott_pkg::SUB_W-1:0]  micros
);
	import ott_pkg::*;

	time_state_t state_q, state_d;

	logic [SEC_W-1:0]  sec_q;
	logic [SUB_W-1:0]  ms_q;
	logic [SUB_W-1:0]  us_q;
	logic [TOT_W-1:0]  total_q;
	logic [PROD_W-1:0] prod_q;

	logic              wrap;
	logic [SUB_W-1:0]  quo;
	logic [TOT_W-2:0]  rem;

	always_comb begin
		wrap = total_q >= TOT_W'(US_PER_S);
		quo  = prod_q[RECIP_SHIFT +: SUB_W];
		rem  = total_q[TOT_W-2:0] - (TOT_W-1)'(quo) * (TOT_W-1)'(US_PER_MS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			TS_IDLE: begin
				if (start) begin
					state_d = TS_WRAP;
				end
			end
			TS_WRAP: begin
				if (!wrap) begin
					state_d = TS_MUL;
				end
			end
			TS_MUL: begin
				state_d = TS_SPLIT;
			end
			TS_SPLIT: begin
				done    = 1'b1;
				state_d = TS_IDLE;
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			sec_q   <= '0;
			ms_q    <= '0;
			us_q    <= '0;
		end else begin
			state_q <= state_d;
			// carry whole seconds out of the sum, at most twice
			if (state_q == TS_WRAP && wrap) begin
				sec_q <= sec_q + 1'b1;
			end
			// split the sub-second part into ms and us
			if (state_q == TS_SPLIT) begin
				ms_q <= quo;
				us_q <= rem[SUB_W-1:0];
			end
		end
	end

	// sum and reciprocal product
	always_ff @(posedge clk) begin
		if (state_q == TS_IDLE && start) begin
			total_q <= TOT_W'(ms_q) * TOT_W'(US_PER_MS) + TOT_W'(us_q) + TOT_W'(len);
		end else if (state_q == TS_WRAP && wrap) begin
			total_q <= total_q - TOT_W'(US_PER_S);
		end
		if (state_q == TS_MUL) begin
			prod_q <= PROD_W'(total_q[TOT_W-2:0]) * PROD_W'(RECIP_1000);
		end
	end

	assign seconds = sec_q;
	assign millis  = ms_q;
	assign micros  = us_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q < SUB_W'(US_PER_MS)) && (us_q < SUB_W'(US_PER_MS)))
		else $error("time of day not normalized");

endmodule

// File: hdl/one_shot_timer_table.sv
// Sequencing: cancel completes on acceptance; read waits for the output register; start runs
//   the 32-step divider plus write-back; tick runs the time update (its wrap step repeats per
//   carried second), the slot walk and the flush, which wait while results stall.
// Throughput: one item at a time; a tick is bounded by the single RAM read port walking the
//   slot table, a start by the shared divider.
// Reset (async, active low) clears all armed flags, the time of day and sets the tick
//   length to 1000 us; the tick-count RAM is not cleared and needs no clearing pass.
module one_shot_timer_table #(
	parameter int SLOTS = ott_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ott_pkg::TICK_W-1:0]   tick_length_us,
	// items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [ott_pkg::SLOT_W-1:0]   slot,
	input  logic [ott_pkg::PERIOD_W-1:0] timeout_us,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [ott_pkg::SLOT_W-1:0]   expired_slot,
	output logic [ott_pkg::SEC_W-1:0]    seconds,
	output logic [ott_pkg::SUB_W-1:0]    milliseconds,
	output logic [ott_pkg::SUB_W-1:0]    microseconds,
	output logic                          last
);
	import ott_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	ctl_state_t state_q, state_d;

	logic [TICK_W-1:0]   tick_q;
	logic [TICK_W-1:0]   len;
	logic [SLOTS-1:0]    armed_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    slot_idx;
	logic                slot_ok;

	// slot walk
	logic [CNT_W-1:0]    idx_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                pend_v_q;
	logic [IDX_W-1:0]    pend_slot_q;
	logic                issue_ok;
	logic                armed_at;
	logic                hit;
	logic                stall;
	logic [PERIOD_W-1:0] dec;

	// RAM
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [PERIOD_W-1:0] ram_wdata;
	logic                ram_re;
	logic [PERIOD_W-1:0] ram_rdata;

	// units
	logic                div_start;
	logic                div_done;
	logic [PERIOD_W-1:0] div_ticks;
	logic                time_start;
	logic                time_done;
	logic [SEC_W-1:0]    tm_sec;
	logic [SUB_W-1:0]    tm_ms;
	logic [SUB_W-1:0]    tm_us;

	// output register
	logic                out_valid_q;
	logic                out_free;
	logic                push;
	logic                push_kind;
	logic [SLOT_W-1:0]   push_slot;
	logic                push_last;
	logic                kind_q;
	logic [SLOT_W-1:0]   xslot_q;
	logic [SEC_W-1:0]    sec_q;
	logic [SUB_W-1:0]    ms_q;
	logic [SUB_W-1:0]    us_q;
	logic                last_q;

	ott_ram #(
		.WIDTH (PERIOD_W),
		.DEPTH (SLOTS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	ott_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(timeout_us),
		.divisor (len),
		.done    (div_done),
		.ticks   (div_ticks)
	);

	ott_time u_time (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (time_start),
		.len    (len),
		.done   (time_done),
		.seconds(tm_sec),
		.millis (tm_ms),
		.micros (tm_us)
	);

	// decode and walk helpers
	always_comb begin
		len      = (tick_q == '0) ? TICK_W'(1) : tick_q;
		slot_ok  = 32'(slot) < SLOTS;
		slot_idx = IDX_W'(slot);
		issue_ok = idx_q < CNT_W'(SLOTS);
		armed_at = armed_q[idx_q[IDX_W-1:0]];
		dec      = ram_rdata - 1'b1;
		hit      = v_s1 && (dec == '0);
		out_free = !out_valid_q || out_ready;
		stall    = hit && pend_v_q && !out_free;
	end

	assign cfg_ready = 1'b1;

	// sequencer
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		time_start = 1'b0;
		push       = 1'b0;
		push_kind  = KIND_EXPIRY;
		push_slot  = '0;
		push_last  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_s1;
		ram_wdata  = dec;
		ram_re     = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode_t'(mode))
						MODE_TICK: begin
							time_start = 1'b1;
							state_d    = CS_TIME;
						end
						MODE_START: begin
							if (slot_ok) begin
								div_start = 1'b1;
								state_d   = CS_DIV;
							end
						end
						MODE_CANCEL: begin
							state_d = CS_IDLE;
						end
						MODE_READ: begin
							state_d = CS_READ;
						end
					endcase
				end
			end
			CS_DIV: begin
				if (div_done) begin
					ram_we    = 1'b1;
					ram_waddr = slot_q;
					ram_wdata = div_ticks;
					state_d   = CS_IDLE;
				end
			end
			CS_TIME: begin
				if (time_done) begin
					state_d = CS_WALK;
				end
			end
			CS_WALK: begin
				if (!stall) begin
					// write back the decremented count, read the next armed slot
					ram_we = v_s1;
					ram_re = issue_ok && armed_at;
					// a new expiry lets the held one go out as not last
					if (hit && pend_v_q) begin
						push      = 1'b1;
						push_slot = SLOT_W'(pend_slot_q);
					end
					if (!issue_ok && !v_s1) begin
						state_d = CS_FLUSH;
					end
				end
			end
			CS_FLUSH: begin
				if (!pend_v_q) begin
					state_d = CS_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_slot = SLOT_W'(pend_slot_q);
					push_last = 1'b1;
					state_d   = CS_IDLE;
				end
			end
			CS_READ: begin
				if (out_free) begin
					push      = 1'b1;
					push_kind = KIND_TIME;
					push_last = 1'b1;
					state_d   = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// control state, armed flags, walk pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			tick_q      <= TICK_LEN_RST;
			armed_q     <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			pend_v_q    <= 1'b0;
			pend_slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				tick_q <= tick_length_us;
			end
			if (state_q == CS_IDLE && in_valid) begin
				slot_q <= slot_idx;
				if (mode_t'(mode) == MODE_CANCEL && slot_ok) begin
					armed_q[slot_idx] <= 1'b0;
				end
			end
			if (state_q == CS_DIV && div_done) begin
				armed_q[slot_q] <= 1'b1;
			end
			if (state_q == CS_TIME && time_done) begin
				idx_q    <= '0;
				v_s1     <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (state_q == CS_WALK && !stall) begin
				if (hit) begin
					armed_q[idx_s1] <= 1'b0;
					pend_v_q        <= 1'b1;
					pend_slot_q     <= idx_s1;
				end
				v_s1   <= issue_ok && armed_at;
				idx_s1 <= idx_q[IDX_W-1:0];
				if (issue_ok) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (state_q == CS_FLUSH && state_d == CS_IDLE) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q  <= push_kind;
			xslot_q <= push_slot;
			sec_q   <= tm_sec;
			ms_q    <= tm_ms;
			us_q    <= tm_us;
			last_q  <= push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign expired_slot = xslot_q;
	assign seconds      = sec_q;
	assign milliseconds = ms_q;
	assign microseconds = us_q;
	assign last         = last_q;

	// the slot in the read stage is armed and holds a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_WALK && v_s1) |-> armed_q[idx_s1])
		else $error("walk stage holds a disarmed slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_WALK && v_s1) |-> (ram_rdata != '0))
		else $error("armed slot read back a zero tick count");

	// a held expiry only exists during a tick's walk or flush
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == CS_WALK || state_q == CS_FLUSH))
		else $error("held expiry outside of a tick");

	// a push never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed while output register busy");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the one-shot timer table: predicted results, random traffic.
module testbench;
	import ott_pkg::*;

	localparam int NSLOTS = SLOTS_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 56;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [SEC_W-1:0]  sec;
		logic [SUB_W-1:0]  ms;
		logic [SUB_W-1:0]  us;
		logic              last;
	} timer_result_t;

	// Mirror of the slot table and time of day, plus the results still owed
	class slot_table_mirror;
		logic [TICK_W-1:0]   tick_len_reg;
		logic [PERIOD_W-1:0] ticks_left[NSLOTS];
		bit                  slot_armed[NSLOTS];
		logic [SEC_W-1:0]    tod_sec;
		logic [SUB_W-1:0]    tod_ms;
		logic [SUB_W-1:0]    tod_us;
		timer_result_t       due_results[$];
		int                  errors;

		function new();
			tick_len_reg = TICK_LEN_RST;
			foreach (slot_armed[i]) begin
				slot_armed[i] = 1'b0;
				ticks_left[i] = '0;
			end
			tod_sec = '0;
			tod_ms = '0;
			tod_us = '0;
			errors = 0;
		endfunction

		function void set_tick_len(logic [TICK_W-1:0] v);
			tick_len_reg = v;
		endfunction

		function int due_count();
			return due_results.size();
		endfunction

		function timer_result_t stamp(logic k, logic [SLOT_W-1:0] s, logic lst);
			timer_result_t r;
			r.kind = k;
			r.slot = s;
			r.sec = tod_sec;
			r.ms = tod_ms;
			r.us = tod_us;
			r.last = lst;
			return r;
		endfunction

		// Work out what one accepted item produces
		function void note_item(mode_t m, logic [SLOT_W-1:0] s, logic [PERIOD_W-1:0] p);
			logic [31:0] len;
			logic [31:0] total;
			logic [31:0] q;
			bit [NSLOTS-1:0] fired;
			int top;
			len = (tick_len_reg == '0) ? 32'd1 : 32'(tick_len_reg);
			case (m)
				MODE_TICK: begin
					// advance the clock, carrying into ms and s
					total = 32'(tod_us) + 32'(tod_ms) * US_PER_MS + len;
					tod_us = SUB_W'(total % US_PER_MS);
					tod_ms = SUB_W'((total / US_PER_MS) % US_PER_MS);
					tod_sec = tod_sec + total / US_PER_S;
					fired = '0;
					top = -1;
					for (int i = 0; i < NSLOTS; i++) begin
						if (slot_armed[i]) begin
							ticks_left[i] = ticks_left[i] - 1;
							if (ticks_left[i] == '0) begin
								slot_armed[i] = 1'b0;
								fired[i] = 1'b1;
								top = i;
							end
						end
					end
					for (int i = 0; i < NSLOTS; i++)
						if (fired[i])
							due_results.push_back(stamp(KIND_EXPIRY, SLOT_W'(i), i == top));
				end
				MODE_START: begin
					// ceiling division, at least one tick
					q = p / len;
					if (q == '0 || p - q * len != '0)
						q = q + 1;
					ticks_left[s] = q;
					slot_armed[s] = 1'b1;
				end
				MODE_CANCEL: slot_armed[s] = 1'b0;
				default: due_results.push_back(stamp(KIND_TIME, '0, 1'b1));
			endcase
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (due_results.size() == 0) begin
				$error("result with nothing pending: slot %0d kind %0d", got.slot, got.kind);
				errors++;
				return;
			end
			want = due_results.pop_front();
			cmp_field("kind", 32'(want.kind), 32'(got.kind));
			cmp_field("expired_slot", 32'(want.slot), 32'(got.slot));
			cmp_field("seconds", want.sec, got.sec);
			cmp_field("milliseconds", 32'(want.ms), 32'(got.ms));
			cmp_field("microseconds", 32'(want.us), 32'(got.us));
			cmp_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TICK_W-1:0]   tick_length_us = TICK_LEN_RST;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mode_t               mode = MODE_READ;
	logic [SLOT_W-1:0]   slot = '0;
	logic [PERIOD_W-1:0] timeout_us = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                kind;
	logic [SLOT_W-1:0]   expired_slot;
	logic [SEC_W-1:0]    seconds;
	logic [SUB_W-1:0]    milliseconds;
	logic [SUB_W-1:0]    microseconds;
	logic                last;

	slot_table_mirror sb = new();

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_reqs = 0;
	int unsigned cur_len = 1000;
	int          cycles = 0;

	one_shot_timer_table uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.tick_length_us (tick_length_us),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.slot           (slot),
		.timeout_us     (timeout_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.expired_slot   (expired_slot),
		.seconds        (seconds),
		.milliseconds   (milliseconds),
		.microseconds   (microseconds),
		.last           (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Monitor: every transfer on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_tick_len(tick_length_us);
			if (in_valid && in_ready)
				sb.note_item(mode, slot, timeout_us);
			if (out_valid && out_ready)
				sb.check_result({kind, expired_slot, seconds, milliseconds, microseconds,
					last});
		end
	end

	// Result side: random backpressure, long hold-off on request
	initial begin : result_sink
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_served != hold_reqs) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_item(input mode_t m, input logic [SLOT_W-1:0] s,
			input logic [PERIOD_W-1:0] p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		slot <= s;
		timeout_us <= p;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stop offering items until nothing is owed and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [TICK_W-1:0] v);
		cfg_valid <= 1'b1;
		tick_length_us <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_len = (v == '0) ? 1 : int'(v);
	endtask

	// Arm every slot to fire on the next tick, then tick
	task automatic arm_all();
		for (int i = 0; i < NSLOTS; i++)
			send_item(MODE_START, SLOT_W'(i), $urandom_range(0, cur_len));
		send_item(MODE_TICK, '0, '0);
	endtask

	task automatic random_item(output int cnt);
		int r;
		logic [PERIOD_W-1:0] p;
		r = $urandom_range(0, 99);
		cnt = 1;
		if (r < 36) begin
			send_item(MODE_TICK, SLOT_W'($urandom()), $urandom());
		end else if (r < 68) begin
			// mostly periods that expire within a few ticks
			if ($urandom_range(0, 9) == 0)
				p = $urandom();
			else
				p = $urandom_range(0, 4 * cur_len);
			send_item(MODE_START, SLOT_W'($urandom_range(0, NSLOTS - 1)), p);
		end else if (r < 80) begin
			send_item(MODE_CANCEL, SLOT_W'($urandom_range(0, NSLOTS - 1)), $urandom());
		end else if (r < 96) begin
			send_item(MODE_READ, SLOT_W'($urandom()), $urandom());
		end else begin
			arm_all();
			cnt = NSLOTS + 1;
		end
	endtask

	initial begin : stimulus
		logic [TICK_W-1:0] cfg_list[7];
		int n;
		int k;
		cfg_list = '{20'd1, 20'd0, 20'hFFFFF, 20'd1000000, 20'd7, 20'd1000, 20'd1};
		cfg_list[6] = TICK_W'($urandom_range(2, 5000));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		tx_idle_pct = 25;
		rx_idle_pct = 63;

		// Directed: reset tick length of 1000 us
		send_item(MODE_READ, '0, '0);
		send_item(MODE_TICK, '0, '0);                    // nothing armed
		send_item(MODE_START, 4'd15, 32'hFFFF_FFFF);     // never fires in this run
		send_item(MODE_START, 4'd0, 32'd0);              // zero period: one tick
		send_item(MODE_START, 4'd1, 32'd1001);           // rounds up to two ticks
		send_item(MODE_START, 4'd2, 32'd2000);
		send_item(MODE_START, 4'd2, 32'd1000);           // restart while armed
		send_item(MODE_CANCEL, 4'd0, '0);
		send_item(MODE_CANCEL, 4'd4, '0);                // idle slot
		send_item(MODE_TICK, '0, '0);                    // slot 2 fires
		send_item(MODE_TICK, '0, '0);                    // slot 1 fires
		send_item(MODE_CANCEL, 4'd15, '0);
		send_item(MODE_READ, '0, '0);

		// Random phases, one tick length each
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 2) begin
				tx_idle_pct = 63;
				rx_idle_pct = 25;
			end
			if (ph == 5) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			settle();
			write_cfg(cfg_list[ph]);
			n = 0;
			if (ph == 3) begin
				// the tick's results back up behind a long receiver stall
				arm_all();
				hold_reqs++;
				n = NSLOTS + 1;
			end
			while (n < ITEMS_PER_PHASE) begin
				if (ph == 5 && n >= ITEMS_PER_PHASE / 2 && n < ITEMS_PER_PHASE / 2 + 1)
					settle();
				random_item(k);
				n += k;
			end
		end

		settle();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
hdl/ott_pkg.sv
hdl/ott_ram.sv
hdl/ott_div.sv
hdl/ott_time.sv
hdl/one_shot_timer_table.sv
tb/testbench.sv
